[rtl/pdp_pkg.sv]
`timescale 1ns / 1ps
package pdp_pkg;

  localparam int COORD_W  = 12;
  localparam int COEF_W   = 16;
  localparam int ORIGIN_W = 13;
  localparam int COLOR_W  = 24;
  localparam int PIX_W    = 7;
  localparam int DEPTH_W  = 14;
  localparam int FRAC_W   = 8;
  localparam int PROD_W   = COORD_W + COEF_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int PROJ_W   = SUM_W - FRAC_W;
  localparam int POS_W    = PROJ_W + 1;
  localparam int CFG_W    = 16;

  typedef enum logic [1:0] {
    ST_OFF     = 2'd0,
    ST_HIDDEN  = 2'd1,
    ST_WRITTEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PX_X    = 3'd0,
    REG_PX_Y    = 3'd1,
    REG_PX_Z    = 3'd2,
    REG_PY_X    = 3'd3,
    REG_PY_Y    = 3'd4,
    REG_PY_Z    = 3'd5,
    REG_ORG_COL = 3'd6,
    REG_ORG_ROW = 3'd7
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ORIGIN_W-1:0] origin_t;
  typedef logic        [COLOR_W-1:0]  color_t;
  typedef logic        [PIX_W-1:0]    pix_t;
  typedef logic signed [DEPTH_W-1:0]  depth_t;

  typedef struct packed {
    logic   valid;
    depth_t depth;
  } depth_entry_t;

endpackage

[rtl/pdp_if.sv]
`timescale 1ns / 1ps
interface pdp_point_if;
  logic             valid;
  logic             ready;
  pdp_pkg::coord_t  point_x;
  pdp_pkg::coord_t  point_y;
  pdp_pkg::coord_t  point_z;
  pdp_pkg::color_t  color;

  modport source (output valid, point_x, point_y, point_z, color, input ready);
  modport sink (input valid, point_x, point_y, point_z, color, output ready);
endinterface

interface pdp_pixel_if;
  logic             valid;
  logic             ready;
  pdp_pkg::status_t status;
  pdp_pkg::pix_t    pixel_col;
  pdp_pkg::pix_t    pixel_row;
  pdp_pkg::color_t  pixel_color;

  modport source (output valid, status, pixel_col, pixel_row, pixel_color, input ready);
  modport sink (input valid, status, pixel_col, pixel_row, pixel_color, output ready);
endinterface

[rtl/pdp_ram.sv]
`timescale 1ns / 1ps
module pdp_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/point_project_depth_plot.sv]
`timescale 1ns / 1ps
// An accepted point passes through the p, s, c and t registers to the output register.
// Throughput: one point per cycle unless the output stalls; the depth store
// read-modify-write is forwarded. Rate is set by the single write and single read
// port of the depth memory. Reset: synchronous rst clears registers, then a
// clearing pass writes every depth memory entry, during which no point is accepted.
module point_project_depth_plot #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  pdp_pkg::cfg_reg_t     cfg_index,
  input  logic [pdp_pkg::CFG_W-1:0] cfg_data,
  pdp_point_if.sink             point,
  pdp_pixel_if.source           pixel
);

  import pdp_pkg::*;

  localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int COL_W  = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int ROW_W  = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
  localparam logic signed [POS_W-1:0] COL_LIM = POS_W'(IMAGE_WIDTH);
  localparam logic signed [POS_W-1:0] ROW_LIM = POS_W'(IMAGE_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(IMAGE_WIDTH);
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << FRAC_W) - 1);

  coef_t   cx_col, cy_col, cz_col, cx_row, cy_row, cz_row;
  origin_t org_col, org_row;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic adv;
  logic accept;

  logic                     p_valid;
  logic signed [PROD_W-1:0] p_cx, p_cy, p_cz, p_rx, p_ry, p_rz;
  depth_t                   p_depth;
  color_t                   p_color;

  logic signed [PROD_W-1:0] m_cx, m_cy, m_cz, m_rx, m_ry, m_rz;

  logic                    s_valid;
  logic signed [SUM_W-1:0] s_col, s_row;
  depth_t                  s_depth;
  color_t                  s_color;

  logic signed [SUM_W-1:0]  col_biased, row_biased;
  logic signed [PROJ_W-1:0] col_q, row_q;
  logic signed [POS_W-1:0]  col_next, row_next;

  logic                    c_valid;
  logic signed [POS_W-1:0] c_col, c_row;
  depth_t                  c_depth;
  color_t                  c_color;

  logic              c_in_img;
  logic [ADDR_W-1:0] c_addr;

  logic              t_valid;
  logic              t_in_img;
  logic [ADDR_W-1:0] t_addr;
  pix_t              t_col, t_row;
  depth_t            t_depth;
  color_t            t_color;

  logic              fw_valid;
  logic [ADDR_W-1:0] fw_addr;
  depth_t            fw_depth;

  depth_entry_t ram_rdata, ram_wdata, stored;
  logic         ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic         t_win;
  logic         t_write;

  logic    out_valid;
  status_t out_status;
  pix_t    out_col, out_row;
  color_t  out_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx_col  <= '0;
      cy_col  <= '0;
      cz_col  <= '0;
      cx_row  <= '0;
      cy_row  <= '0;
      cz_row  <= '0;
      org_col <= '0;
      org_row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PX_X:    cx_col  <= coef_t'(cfg_data);
        REG_PX_Y:    cy_col  <= coef_t'(cfg_data);
        REG_PX_Z:    cz_col  <= coef_t'(cfg_data);
        REG_PY_X:    cx_row  <= coef_t'(cfg_data);
        REG_PY_Y:    cy_row  <= coef_t'(cfg_data);
        REG_PY_Z:    cz_row  <= coef_t'(cfg_data);
        REG_ORG_COL: org_col <= cfg_data[ORIGIN_W-1:0];
        REG_ORG_ROW: org_row <= cfg_data[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  assign adv         = !out_valid || pixel.ready;
  assign point.ready = adv && !clearing;
  assign accept      = point.valid && point.ready;

  always_comb begin
    m_cx = PROD_W'(point.point_x) * PROD_W'(cx_col);
    m_cy = PROD_W'(point.point_y) * PROD_W'(cy_col);
    m_cz = PROD_W'(point.point_z) * PROD_W'(cz_col);
    m_rx = PROD_W'(point.point_x) * PROD_W'(cx_row);
    m_ry = PROD_W'(point.point_y) * PROD_W'(cy_row);
    m_rz = PROD_W'(point.point_z) * PROD_W'(cz_row);
  end

  always_comb begin
    col_biased = s_col + (s_col[SUM_W-1] ? ROUND_BIAS : '0);
    row_biased = s_row + (s_row[SUM_W-1] ? ROUND_BIAS : '0);
    col_q      = col_biased[SUM_W-1:FRAC_W];
    row_q      = row_biased[SUM_W-1:FRAC_W];
    col_next   = POS_W'(col_q) + POS_W'(org_col);
    row_next   = POS_W'(row_q) + POS_W'(org_row);
  end

  always_comb begin
    c_in_img = !c_col[POS_W-1] && (c_col < COL_LIM) &&
               !c_row[POS_W-1] && (c_row < ROW_LIM);
    c_addr   = ADDR_W'(c_row[ROW_W-1:0]) * ROW_STRIDE + ADDR_W'(c_col[COL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      c_valid <= 1'b0;
      t_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= accept;
      s_valid <= p_valid;
      c_valid <= s_valid;
      t_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cx     <= m_cx;
      p_cy     <= m_cy;
      p_cz     <= m_cz;
      p_rx     <= m_rx;
      p_ry     <= m_ry;
      p_rz     <= m_rz;
      p_depth  <= DEPTH_W'(point.point_x) + DEPTH_W'(point.point_y) +
                  DEPTH_W'(point.point_z);
      p_color  <= point.color;
      s_col    <= SUM_W'(p_cx) + SUM_W'(p_cy) + SUM_W'(p_cz);
      s_row    <= SUM_W'(p_rx) + SUM_W'(p_ry) + SUM_W'(p_rz);
      s_depth  <= p_depth;
      s_color  <= p_color;
      c_col    <= col_next;
      c_row    <= row_next;
      c_depth  <= s_depth;
      c_color  <= s_color;
      t_in_img <= c_in_img;
      t_addr   <= c_addr;
      t_col    <= c_col[PIX_W-1:0];
      t_row    <= c_row[PIX_W-1:0];
      t_depth  <= c_depth;
      t_color  <= c_color;
    end
  end

  assign stored  = (fw_valid && fw_addr == t_addr) ?
                   depth_entry_t'{valid: 1'b1, depth: fw_depth} : ram_rdata;
  assign t_win   = !stored.valid || (t_depth > stored.depth);
  assign t_write = t_valid && t_in_img && t_win;

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = depth_entry_t'{valid: 1'b0, depth: '0};
    end else begin
      ram_we    = adv && t_write;
      ram_waddr = t_addr;
      ram_wdata = depth_entry_t'{valid: 1'b1, depth: t_depth};
    end
  end

  pdp_ram #(
    .WIDTH($bits(depth_entry_t)),
    .DEPTH(PIXELS)
  ) u_depth_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (adv),
    .raddr(c_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (adv) begin
      fw_valid <= t_write;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_addr  <= t_addr;
      fw_depth <= t_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!t_in_img) begin
        out_status <= ST_OFF;
        out_col    <= '0;
        out_row    <= '0;
        out_color  <= '0;
      end else if (t_win) begin
        out_status <= ST_WRITTEN;
        out_col    <= t_col;
        out_row    <= t_row;
        out_color  <= t_color;
      end else begin
        out_status <= ST_HIDDEN;
        out_col    <= '0;
        out_row    <= '0;
        out_color  <= '0;
      end
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.status      = out_status;
  assign pixel.pixel_col   = out_col;
  assign pixel.pixel_row   = out_row;
  assign pixel.pixel_color = out_color;

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(p_valid || s_valid || c_valid || t_valid || out_valid))
    else $error("item in flight during depth memory clear");

  a_clear_no_accept: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !point.ready)
    else $error("point accepted during depth memory clear");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_WRITTEN) |->
      (out_col == '0 && out_row == '0 && out_color == '0))
    else $error("non-written result carries pixel data");

  a_forward_tracks: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clearing) |=> (fw_valid && fw_addr == $past(ram_waddr) &&
                               fw_depth == $past(ram_wdata.depth)))
    else $error("forwarding register missed a depth write");

endmodule

[bench/point_project_depth_plot_tb.sv]
`timescale 1ns / 1ps
module point_project_depth_plot_tb;
  import pdp_pkg::*;

  localparam int IMG_W        = 128;
  localparam int IMG_H        = 128;
  localparam int PIXELS       = IMG_W * IMG_H;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 100000;

  typedef struct packed {
    status_t status;
    pix_t    col;
    pix_t    row;
    color_t  color;
  } pixel_word_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pdp_point_if point_bus();
  pdp_pixel_if pixel_bus();

  point_project_depth_plot #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .point    (point_bus),
    .pixel    (pixel_bus)
  );

  // projection settings and depth buffer as the block should hold them
  coef_t   proj_coef [6];
  origin_t org_col;
  origin_t org_row;
  depth_t  depth_seen [PIXELS];
  bit      depth_set [PIXELS];

  pixel_word_t pending_pixels[$];

  int mismatches = 0;
  int n_points = 0;
  int n_written = 0;
  int n_hidden = 0;
  int n_off = 0;
  int n_settings = 0;
  int quiet_cycles = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  bit aimed = 1'b0;
  int win_x, win_y, win_z;
  int spread = 2;

  always #2 clk = ~clk;

  function automatic pixel_word_t project_and_test(coord_t x, coord_t y, coord_t z,
                                                   color_t c);
    pixel_word_t w;
    longint      col;
    longint      row;
    depth_t      d;
    int          idx;
    col = (longint'(x) * proj_coef[REG_PX_X] + longint'(y) * proj_coef[REG_PX_Y]
           + longint'(z) * proj_coef[REG_PX_Z]) / 256 + longint'(org_col);
    row = (longint'(x) * proj_coef[REG_PY_X] + longint'(y) * proj_coef[REG_PY_Y]
           + longint'(z) * proj_coef[REG_PY_Z]) / 256 + longint'(org_row);
    d = depth_t'(int'(x) + int'(y) + int'(z));
    w = '0;
    w.status = ST_OFF;
    if (col < 0 || col >= IMG_W || row < 0 || row >= IMG_H) begin
      return w;
    end
    idx = int'(row) * IMG_W + int'(col);
    if (depth_set[idx] && d <= depth_seen[idx]) begin
      w.status = ST_HIDDEN;
      return w;
    end
    depth_set[idx] = 1'b1;
    depth_seen[idx] = d;
    w.status = ST_WRITTEN;
    w.col = pix_t'(col);
    w.row = pix_t'(row);
    w.color = c;
    return w;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && point_bus.valid && point_bus.ready) begin
      pending_pixels.push_back(project_and_test(point_bus.point_x, point_bus.point_y,
                                                point_bus.point_z, point_bus.color));
      n_points++;
    end
  end

  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst && pixel_bus.valid && pixel_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel word, expected none, got status %0d col %0d row %0d",
                 $time, pixel_bus.status, pixel_bus.pixel_col, pixel_bus.pixel_row);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("status", 32'(want.status), 32'(pixel_bus.status));
        compare_field("pixel_col", 32'(want.col), 32'(pixel_bus.pixel_col));
        compare_field("pixel_row", 32'(want.row), 32'(pixel_bus.pixel_row));
        compare_field("pixel_color", 32'(want.color), 32'(pixel_bus.pixel_color));
        case (want.status)
          ST_WRITTEN: n_written++;
          ST_HIDDEN:  n_hidden++;
          default:    n_off++;
        endcase
      end
    end
  end

  // hold off for a long stretch on request, otherwise stall at random
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pixel_bus.ready <= 1'b0;
    end else begin
      pixel_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((point_bus.valid && point_bus.ready) || (pixel_bus.valid && pixel_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("point_project_depth_plot verification failed");
        $finish;
      end
    end
  end

  task automatic load_projection(input int pxx, input int pxy, input int pxz,
                                 input int pyx, input int pyy, input int pyz,
                                 input int ocol, input int orow);
    logic [CFG_W-1:0] words [8];
    int               i;
    words[REG_PX_X]    = pxx[CFG_W-1:0];
    words[REG_PX_Y]    = pxy[CFG_W-1:0];
    words[REG_PX_Z]    = pxz[CFG_W-1:0];
    words[REG_PY_X]    = pyx[CFG_W-1:0];
    words[REG_PY_Y]    = pyy[CFG_W-1:0];
    words[REG_PY_Z]    = pyz[CFG_W-1:0];
    words[REG_ORG_COL] = ocol[CFG_W-1:0];
    words[REG_ORG_ROW] = orow[CFG_W-1:0];
    for (i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= words[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    for (i = 0; i < 6; i++) begin
      proj_coef[i] = words[i];
    end
    org_col = words[REG_ORG_COL][ORIGIN_W-1:0];
    org_row = words[REG_ORG_ROW][ORIGIN_W-1:0];
    n_settings++;
  endtask

  task automatic send_point(input int x, input int y, input int z, input int c);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      point_bus.valid <= 1'b0;
      @(negedge clk);
    end
    point_bus.valid   <= 1'b1;
    point_bus.point_x <= x[COORD_W-1:0];
    point_bus.point_y <= y[COORD_W-1:0];
    point_bus.point_z <= z[COORD_W-1:0];
    point_bus.color   <= c[COLOR_W-1:0];
    @(posedge clk);
    while (!point_bus.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    point_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // center a small window of points on the middle of the image
  task automatic aim_projection();
    int a, b, c, d, e, f;
    a = $urandom_range(64, 512);
    if ($urandom_range(0, 1)) a = -a;
    e = $urandom_range(64, 512);
    if ($urandom_range(0, 1)) e = -e;
    b = int'($urandom_range(0, 64)) - 32;
    c = int'($urandom_range(0, 64)) - 32;
    d = int'($urandom_range(0, 64)) - 32;
    f = int'($urandom_range(0, 64)) - 32;
    spread = 1 << $urandom_range(1, 4);
    win_x = int'($urandom_range(0, 3000)) - 1500;
    win_y = int'($urandom_range(0, 3000)) - 1500;
    win_z = int'($urandom_range(0, 3000)) - 1500;
    aimed = 1'b1;
    load_projection(a, b, c, d, e, f,
                    64 - (a * win_x + b * win_y + c * win_z) / 256,
                    64 - (d * win_x + e * win_y + f * win_z) / 256);
  endtask

  task automatic send_random_point();
    int x, y, z;
    if (aimed && $urandom_range(0, 99) < 85) begin
      x = win_x + int'($urandom_range(0, spread)) - spread / 2;
      y = win_y + int'($urandom_range(0, spread)) - spread / 2;
      z = win_z + int'($urandom_range(0, 4 * spread)) - 2 * spread;
    end else begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end
    send_point(x, y, z, $urandom);
  endtask

  task automatic test_depth_order();
    wait_for_results();
    load_projection(256, 0, 0, 0, 256, 0, 0, 0);
    send_point(0, 0, 0, 0);
    send_point(0, 0, 0, 'hFFFFFF);
    send_point(0, 0, -1, 'h123456);
    send_point(0, 0, 1, 'hABCDEF);
    send_point(127, 127, 2047, 'hFFFFFF);
    send_point(127, 127, -2048, 'h000001);
    send_point(127, 0, 0, 'h800000);
    send_point(0, 127, 0, 'h7FFFFF);
    send_point(128, 0, 0, 'h111111);
    send_point(-1, 0, 0, 'h222222);
    send_point(0, 128, 0, 'h333333);
    send_point(0, -1, 0, 'h444444);
    send_point(2047, 2047, 2047, 'h555555);
    send_point(-2048, -2048, -2048, 'h666666);
  endtask

  task automatic test_truncation();
    wait_for_results();
    load_projection(-128, 0, 0, 0, 128, -64, 10, 0);
    send_point(3, 3, 0, 'h0F0F0F);
    send_point(-3, -1, 0, 'hF0F0F0);
    send_point(1, 0, 1, 'hAAAAAA);
    send_point(0, 0, 4, 'h555555);
  endtask

  task automatic test_register_extremes();
    wait_for_results();
    load_projection(-32768, 0, 0, 0, 32767, 0, 4095, -4096);
    send_point(31, 33, 0, 'hC0FFEE);
    send_point(32, 33, 0, 'h00FF00);
    send_point(31, 32, 0, 'hFF0000);
    send_point(31, 33, -2048, 'h0000FF);
    wait_for_results();
    load_projection(32767, -32768, 32767, -32768, 32767, -32768, -4096, 4095);
    send_point(0, 0, 0, 'h101010);
    send_point(-2048, 2047, -2048, 'hEFEFEF);
  endtask

  task automatic test_random_traffic();
    int phase, k, n;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (k = 0; k < 4; k++) begin
        wait_for_results();
        if (k == 3) begin
          aimed = 1'b0;
          load_projection($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
        end else begin
          aim_projection();
        end
        for (n = 0; n < 50; n++) begin
          send_random_point();
        end
      end
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    int n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_for_results();
    aim_projection();
    hold_request = 1'b1;
    for (n = 0; n < 60; n++) begin
      send_random_point();
    end
    wait_for_results();
    for (n = 0; n < 20; n++) begin
      send_random_point();
    end
    wait_for_results();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PX_X;
    cfg_data = '0;
    point_bus.valid = 1'b0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    point_bus.point_z = '0;
    point_bus.color = '0;
    pixel_bus.ready = 1'b0;
    for (int i = 0; i < 6; i++) proj_coef[i] = '0;
    org_col = '0;
    org_row = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_depth_order();
    test_truncation();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    wait_for_results();

    $display("covered %0d points over %0d projection settings and four idle mixes",
             n_points, n_settings);
    $display("results: %0d written, %0d hidden, %0d off image, %0d mismatches",
             n_written, n_hidden, n_off, mismatches);
    if (mismatches == 0) begin
      $display("point_project_depth_plot verification clean");
    end else begin
      $display("point_project_depth_plot verification failed");
    end
    $finish;
  end

endmodule
